FILE: design/multi_channel_pwm_pulse_capture_macros.svh
// Assertion macros for the pulse capture block
`ifndef MULTI_CHANNEL_PWM_PULSE_CAPTURE_MACROS_SVH
`define MULTI_CHANNEL_PWM_PULSE_CAPTURE_MACROS_SVH
`ifndef SYNTHESIS
`define MPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: design/mpc_pkg.sv
// Shared types and constants of the pulse capture block
`default_nettype none
package mpc_pkg;
  localparam int Channels = 6;
  localparam int ChW = 3;
  localparam logic [11:0] ValidMinUs = 12'd800;
  localparam logic [11:0] ValidMaxUs = 12'd2200;
  localparam logic [11:0] CalLimitMinUs = 12'd800;
  localparam logic [11:0] CalLimitMaxUs = 12'd2200;
  localparam logic [11:0] DefaultTimeoutMs = 12'd500;
  localparam logic [2:0] RegTimeout = 3'd0;
  localparam logic [2:0] RegCalMin = 3'd1;
  localparam logic [2:0] RegCalTrim = 3'd2;
  localparam logic [2:0] RegCalMax = 3'd3;
  localparam logic [2:0] RegChanEn = 3'd4;
  localparam logic [1:0] QualInvalid = 2'd0;
  localparam logic [1:0] QualStale = 2'd1;
  localparam logic [1:0] QualValid = 2'd2;
  typedef struct packed {
    logic edge_go;
    logic tick_go;
    logic chan_start;
    logic div_start;
    logic chan_finish;
    logic [ChW-1:0] chan;
  } cmd_t;
  typedef struct packed {
    logic div_done;
    logic need_div;
  } sts_t;
endpackage
`default_nettype wire

FILE: design/mpc_ctrl.sv
// Controller state machine of the pulse capture block
`default_nettype none
`include "multi_channel_pwm_pulse_capture_macros.svh"
module mpc_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic func_i,
  output logic out_valid,
  input  wire logic out_stall,
  input  wire mpc_pkg::sts_t sts_i,
  output mpc_pkg::cmd_t cmd_o,
  output logic last_o
);
  import mpc_pkg::*;
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPrep = 3'd1;
  localparam logic [2:0] SDiv = 3'd2;
  localparam logic [2:0] SWait = 3'd3;
  localparam logic [2:0] SOut = 3'd4;
  logic [2:0] state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic acc;
  assign in_stall = (state_q != SIdle);
  assign acc = in_valid && !in_stall;
  assign out_valid = (state_q == SOut);
  assign last_o = (ch_q == ChW'(Channels - 1));
  always_comb begin
    state_d = state_q;
    ch_d = ch_q;
    cmd_o = '0;
    cmd_o.chan = ch_q;
    case (state_q)
      SIdle: begin
        if (acc && !func_i) begin
          cmd_o.edge_go = 1'b1;
        end else if (acc) begin
          cmd_o.tick_go = 1'b1;
          ch_d = '0;
          state_d = SPrep;
        end
      end
      SPrep: begin
        cmd_o.chan_start = 1'b1;
        state_d = SDiv;
      end
      SDiv: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = SWait;
        end else begin
          cmd_o.chan_finish = 1'b1;
          state_d = SOut;
        end
      end
      SWait: begin
        if (sts_i.div_done) begin
          cmd_o.chan_finish = 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        if (!out_stall) begin
          if (last_o) begin
            state_d = SIdle;
          end else begin
            ch_d = ch_q + 1'b1;
            state_d = SPrep;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ch_q <= '0;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d;
    end
  end
  `MPC_ASSERT(a_ch_range, clk_i, rst_ni, ch_q < ChW'(Channels), "channel out of range")
  `MPC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid && out_stall) |=> out_valid, "beat lost")
  `MPC_ASSERT_NEVER(a_busy_acc, clk_i, rst_ni, acc && state_q != SIdle, "accept while busy")
endmodule
`default_nettype wire

FILE: design/mpc_datapath.sv
// Capture state, pulse intake, divider and quality of the pulse capture block
`default_nettype none
module mpc_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire mpc_pkg::cmd_t cmd_i,
  output mpc_pkg::sts_t sts_o,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [11:0] cfg_data,
  input  wire logic [2:0] edge_channel_i,
  input  wire logic edge_level_i,
  input  wire logic [31:0] edge_time_i,
  input  wire logic [63:0] now_time_i,
  output logic [1:0] quality_o,
  output logic signed [15:0] norm_value_o,
  output logic [15:0] raw_width_o,
  output logic [63:0] pulse_time_o
);
  import mpc_pkg::*;
  logic [11:0] tmo_q, cmin_q, ctrim_q, cmax_q;
  logic [5:0] en_q;
  logic [31:0] rise_time_q [Channels];
  logic [Channels-1:0] rise_seen_q, pend_q, seen_q, ok_q;
  logic [31:0] pw_q [Channels];
  logic [31:0] pt_q [Channels];
  logic [15:0] lw_q [Channels];
  logic [63:0] lt_q [Channels];
  logic [15:0] hv_q [Channels];
  logic [63:0] now_q;
  logic [21:0] tus_q;
  logic [15:0] w_q;
  logic [63:0] ext_q;
  logic take_q, ok_w_q, neg_q;
  logic [27:0] num_q, rem_q;
  logic [11:0] den_q;
  logic [27:0] quo_q;
  logic [4:0] cnt_q;
  logic busy_q;
  logic [ChW-1:0] c;
  logic edge_ok;
  logic cal_ok;
  logic [11:0] tms;
  logic [15:0] wsat;
  logic [31:0] dlt;
  logic [11:0] trim_e;
  logic [15:0] diff;
  logic [11:0] den;
  logic [28:0] rtry;
  logic [16:0] qsel;
  logic signed [15:0] nv;
  logic [63:0] age;
  assign c = cmd_i.chan;
  assign edge_ok = (edge_channel_i < ChW'(Channels)) && en_q[edge_channel_i];
  assign cal_ok = (cmin_q >= CalLimitMinUs) && (cmax_q <= CalLimitMaxUs)
               && (cmin_q < ctrim_q) && (ctrim_q < cmax_q);
  assign tms = (tmo_q < 12'd20 || tmo_q > 12'd2000) ? DefaultTimeoutMs : tmo_q;
  assign wsat = (pw_q[c][31:16] != '0) ? 16'hFFFF : pw_q[c][15:0];
  assign dlt = now_q[31:0] - pt_q[c];
  assign trim_e = ctrim_q;
  assign diff = (w_q < {4'd0, trim_e}) ? ({4'd0, trim_e} - w_q) : (w_q - {4'd0, trim_e});
  assign den = (w_q < {4'd0, trim_e}) ? (ctrim_q - cmin_q) : (cmax_q - ctrim_q);
  assign sts_o.need_div = take_q && ok_w_q;
  assign sts_o.div_done = busy_q && (cnt_q == 5'd0);
  assign rtry = {rem_q, num_q[27]} - {17'd0, den_q};
  assign qsel = neg_q ? ((quo_q > 28'd32768) ? 17'd32768 : quo_q[16:0])
                      : ((quo_q > 28'd32767) ? 17'd32767 : quo_q[16:0]);
  assign nv = neg_q ? -$signed(qsel[15:0]) : $signed(qsel[15:0]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= 12'd500; cmin_q <= 12'd1100; ctrim_q <= 12'd1500; cmax_q <= 12'd1900;
      en_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegTimeout: tmo_q <= cfg_data;
        RegCalMin: cmin_q <= cfg_data;
        RegCalTrim: ctrim_q <= cfg_data;
        RegCalMax: cmax_q <= cfg_data;
        RegChanEn: en_q <= cfg_data[5:0];
        default: ;
      endcase
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_seen_q <= '0; pend_q <= '0; seen_q <= '0; ok_q <= '0;
      busy_q <= 1'b0; cnt_q <= '0; take_q <= 1'b0;
      now_q <= '0; tus_q <= '0; w_q <= '0; ext_q <= '0; ok_w_q <= 1'b0; neg_q <= 1'b0;
      num_q <= '0; rem_q <= '0; den_q <= '0; quo_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        rise_time_q[i] <= '0; pw_q[i] <= '0; pt_q[i] <= '0;
        lw_q[i] <= '0; lt_q[i] <= '0; hv_q[i] <= '0;
      end
    end else begin
      if (cmd_i.edge_go && edge_ok) begin
        if (edge_level_i) begin
          rise_time_q[edge_channel_i] <= edge_time_i;
          rise_seen_q[edge_channel_i] <= 1'b1;
        end else if (rise_seen_q[edge_channel_i]) begin
          pw_q[edge_channel_i] <= edge_time_i - rise_time_q[edge_channel_i];
          pt_q[edge_channel_i] <= edge_time_i;
          rise_seen_q[edge_channel_i] <= 1'b0;
          pend_q[edge_channel_i] <= 1'b1;
        end
      end
      if (cmd_i.tick_go) begin
        now_q <= now_time_i;
        tus_q <= 22'(tms) * 22'd1000;
      end
      if (cmd_i.chan_start) begin
        take_q <= pend_q[c];
        w_q <= wsat;
        ext_q <= now_q - {32'd0, dlt};
        ok_w_q <= cal_ok && (wsat >= {4'd0, ValidMinUs}) && (wsat <= {4'd0, ValidMaxUs});
        pend_q[c] <= 1'b0;
      end
      if (cmd_i.div_start) begin
        neg_q <= (w_q < {4'd0, trim_e});
        num_q <= {diff[12:0], 15'd0} + {17'd0, den[11:1]};
        den_q <= den;
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 5'd28;
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q != 5'd0) begin
        if (!rtry[28]) begin
          rem_q <= rtry[27:0];
          quo_q <= {quo_q[26:0], 1'b1};
        end else begin
          rem_q <= {rem_q[26:0], num_q[27]};
          quo_q <= {quo_q[26:0], 1'b0};
        end
        num_q <= {num_q[26:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.chan_finish && take_q) begin
        lw_q[c] <= w_q;
        lt_q[c] <= ext_q;
        seen_q[c] <= 1'b1;
        ok_q[c] <= ok_w_q;
        hv_q[c] <= ok_w_q ? nv : 16'sd0;
      end
    end
  end
  assign age = now_q - lt_q[c];
  always_comb begin
    if (!seen_q[c] || !ok_q[c] || lt_q[c] > now_q) quality_o = QualInvalid;
    else if (age > {42'd0, tus_q}) quality_o = QualStale;
    else quality_o = QualValid;
  end
  assign norm_value_o = hv_q[c];
  assign raw_width_o = lw_q[c];
  assign pulse_time_o = lt_q[c];
endmodule
`default_nettype wire

FILE: design/multi_channel_pwm_pulse_capture.sv
// Top level of the multi-channel PWM pulse capture block
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | func, edge fields, now_time
//  out     | out_valid / out_stall| channel, quality, value, width, time, last
//  cfg     | cfg_we               | cfg_idx, cfg_data
// An edge beat leaves the block idle. A tick gives six beats, one per channel;
// each channel passes the prep, divide and output states, using the shared
// restoring divider when a valid pulse is taken in. Reset clears all channel
// state at once. Output stall holds the current beat and the whole tick run.
`default_nettype none
module multi_channel_pwm_pulse_capture (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic func_i,
  input  wire logic [2:0] edge_channel_i,
  input  wire logic edge_level_i,
  input  wire logic [31:0] edge_time_i,
  input  wire logic [63:0] now_time_i,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] out_channel_o,
  output logic [1:0] quality_o,
  output logic signed [15:0] norm_value_o,
  output logic [15:0] raw_width_o,
  output logic [63:0] pulse_time_o,
  output logic last_o,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [11:0] cfg_data
);
  import mpc_pkg::*;
  cmd_t cmd;
  sts_t sts;
  mpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .func_i, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd), .last_o
  );
  mpc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we, .cfg_idx, .cfg_data,
    .edge_channel_i, .edge_level_i, .edge_time_i, .now_time_i,
    .quality_o, .norm_value_o, .raw_width_o, .pulse_time_o
  );
  assign out_channel_o = cmd.chan;
endmodule
`default_nettype wire

FILE: dv/mpc_checker.sv
// Checker for the pulse capture block: mirrors its state, predicts tick beats, compares
module mpc_checker
  import mpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func_i,
  input  logic [2:0]  edge_channel_i,
  input  logic        edge_level_i,
  input  logic [31:0] edge_time_i,
  input  logic [63:0] now_time_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_channel_o,
  input  logic [1:0]  quality_o,
  input  logic [15:0] norm_value_o,
  input  logic [15:0] raw_width_o,
  input  logic [63:0] pulse_time_o,
  input  logic        last_o,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending_beats,
  output int          ticks_seen,
  output int          valid_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  chan;
    logic [1:0]  qual;
    logic [15:0] value;
    logic [15:0] width;
    logic [63:0] ptime;
    logic        last;
  } beat_t;

  beat_t       exp_beats[$];
  logic [11:0] timeout_r, cmin_r, ctrim_r, cmax_r;
  logic [5:0]  chan_en_r;
  logic [31:0] rise_t[Channels];
  logic        rise_ok[Channels];
  logic        pend[Channels];
  logic [31:0] pend_w[Channels];
  logic [31:0] pend_t[Channels];
  logic [15:0] width_r[Channels];
  logic [63:0] ptime_r[Channels];
  logic        seen_r[Channels];
  logic        ok_r[Channels];
  logic [15:0] hold_r[Channels];

  function automatic logic cal_good();
    return cmin_r >= CalLimitMinUs && cmax_r <= CalLimitMaxUs &&
           cmin_r < ctrim_r && ctrim_r < cmax_r;
  endfunction

  function automatic logic [15:0] scale_width(logic [15:0] w);
    longint unsigned den, q;
    if (w < ctrim_r) begin
      den = ctrim_r - cmin_r;
      q = ((longint'(ctrim_r) - w) * 32768 + den / 2) / den;
      if (q > 32768) q = 32768;
      return 16'(-q);
    end
    den = cmax_r - ctrim_r;
    q = ((longint'(w) - ctrim_r) * 32768 + den / 2) / den;
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  task automatic run_tick(logic [63:0] now);
    longint unsigned tus;
    logic [15:0] w;
    logic [31:0] age32;
    beat_t b;
    tus = (timeout_r < 20 || timeout_r > 2000) ? DefaultTimeoutMs : timeout_r;
    tus = tus * 1000;
    for (int c = 0; c < Channels; c++) begin
      if (pend[c]) begin
        pend[c] = 0;
        w = (pend_w[c] > 65535) ? 16'hFFFF : pend_w[c][15:0];
        age32 = now[31:0] - pend_t[c];
        ptime_r[c] = now - {32'd0, age32};
        width_r[c] = w;
        seen_r[c] = 1;
        ok_r[c] = cal_good() && w >= ValidMinUs && w <= ValidMaxUs;
        hold_r[c] = ok_r[c] ? scale_width(w) : 16'd0;
      end
      b.chan = c[2:0];
      if (!seen_r[c] || !ok_r[c] || ptime_r[c] > now) b.qual = QualInvalid;
      else if (now - ptime_r[c] > tus) b.qual = QualStale;
      else b.qual = QualValid;
      b.value = hold_r[c];
      b.width = width_r[c];
      b.ptime = ptime_r[c];
      b.last = (c == Channels - 1);
      exp_beats.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e, a;
    int c;
    if (!rst_ni) begin
      timeout_r = 500; cmin_r = 1100; ctrim_r = 1500; cmax_r = 1900; chan_en_r = 0;
      for (int i = 0; i < Channels; i++) begin
        rise_t[i] = 0; rise_ok[i] = 0; pend[i] = 0; pend_w[i] = 0; pend_t[i] = 0;
        width_r[i] = 0; ptime_r[i] = 0; seen_r[i] = 0; ok_r[i] = 0; hold_r[i] = 0;
      end
      exp_beats.delete();
      fail_count = 0; pending_beats = 0; ticks_seen = 0; valid_beats = 0;
    end else begin
      if (out_valid && !out_stall) begin
        a = '{out_channel_o, quality_o, norm_value_o, raw_width_o, pulse_time_o, last_o};
        if (exp_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected out beat %p", a);
        end else begin
          e = exp_beats.pop_front();
          if (a !== e) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", e, a);
          end
          if (e.qual == QualValid) valid_beats++;
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          RegTimeout: timeout_r = cfg_data;
          RegCalMin:  cmin_r = cfg_data;
          RegCalTrim: ctrim_r = cfg_data;
          RegCalMax:  cmax_r = cfg_data;
          RegChanEn:  chan_en_r = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (func_i) begin
          run_tick(now_time_i);
          ticks_seen++;
        end else if (edge_channel_i < Channels && chan_en_r[edge_channel_i]) begin
          c = edge_channel_i;
          if (edge_level_i) begin
            rise_t[c] = edge_time_i; rise_ok[c] = 1;
          end else if (rise_ok[c]) begin
            pend_w[c] = edge_time_i - rise_t[c];
            pend_t[c] = edge_time_i;
            rise_ok[c] = 0;
            pend[c] = 1;
          end
        end
      end
      pending_beats = exp_beats.size();
    end
  end
endmodule

FILE: dv/tb_multi_channel_pwm_pulse_capture.sv
// Testbench top for the pulse capture block: stimulus, configuration and verdict
module tb_multi_channel_pwm_pulse_capture;
  import mpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        in_valid, in_stall, func_i, edge_level_i;
  logic [2:0]  edge_channel_i;
  logic [31:0] edge_time_i;
  logic [63:0] now_time_i;
  logic        out_valid, out_stall, last_o;
  logic [2:0]  out_channel_o;
  logic [1:0]  quality_o;
  logic signed [15:0] norm_value_o;
  logic [15:0] raw_width_o;
  logic [63:0] pulse_time_o;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [11:0] cfg_data;
  int          fail_count, pending_beats, ticks_seen, valid_beats;
  int          send_idle_pct, stall_pct, edges_sent;
  logic [63:0] clock_us;

  multi_channel_pwm_pulse_capture u_dut (.*);

  mpc_checker u_chk (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_multi_channel_pwm_pulse_capture: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_beat(logic f, logic [2:0] ch, logic lvl, logic [31:0] t,
                           logic [63:0] now);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid = 1; func_i = f; edge_channel_i = ch; edge_level_i = lvl;
    edge_time_i = t; now_time_i = now;
    forever begin
      stalled = in_stall;
      @(posedge clk_i);
      if (!stalled) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid = 0;
    if (!f) edges_sent++;
  endtask

  task automatic tick(logic [63:0] now);
    send_beat(1'b1, 3'($urandom), 1'($urandom), $urandom, now);
  endtask

  task automatic pulse(logic [2:0] ch, logic [31:0] t0, logic [31:0] w);
    send_beat(0, ch, 1, t0, {$urandom, $urandom});
    send_beat(0, ch, 0, t0 + w, {$urandom, $urandom});
  endtask

  task automatic drain();
    while (pending_beats != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    cfg_we = 1; cfg_idx = idx; cfg_data = val;
    @(negedge clk_i);
    cfg_we = 0;
  endtask

  task automatic set_cal(logic [11:0] tmo, logic [11:0] mn, logic [11:0] tr,
                         logic [11:0] mx);
    drain();
    write_reg(RegTimeout, tmo);
    write_reg(RegCalMin, mn);
    write_reg(RegCalTrim, tr);
    write_reg(RegCalMax, mx);
  endtask

  task automatic random_phase(int n);
    logic [31:0] w;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      clock_us += 64'($urandom_range(30000));
      if (r < 55) begin
        case ($urandom_range(3))
          0: w = $urandom_range(2400, 600);
          1: w = $urandom_range(2200, 800);
          2: w = $urandom;
          default: w = $urandom_range(4095);
        endcase
        pulse(3'($urandom_range(5)), clock_us[31:0], w);
      end else if (r < 70) begin
        send_beat(1'b0, 3'($urandom), 1'($urandom), $urandom, {$urandom, $urandom});
      end else if (r < 95) begin
        tick(clock_us + 64'($urandom_range(2_500_000)));
      end else begin
        tick({$urandom, $urandom});
      end
    end
  endtask

  initial begin
    in_valid = 0; func_i = 0; edge_channel_i = 0; edge_level_i = 0;
    edge_time_i = 0; now_time_i = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    out_stall = 0; send_idle_pct = 0; stall_pct = 0; edges_sent = 0;
    clock_us = 64'h0000_0001_FFFF_0000;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: disabled channels, edge cases under reset calibration, then a boundary calibration
    pulse(0, 100, 1500);
    tick(64'd2000);
    drain();
    write_reg(RegChanEn, 12'h03F);
    send_beat(0, 1, 0, 50, 0);
    send_beat(0, 7, 1, 50, 0);
    pulse(0, 32'hFFFF_FF00, 1100);
    send_beat(0, 1, 1, 10, 0);
    pulse(1, 20, 1900);
    pulse(2, 0, 800);
    pulse(3, 0, 2200);
    pulse(4, 0, 799);
    pulse(5, 0, 32'hFFFF_FFFF);
    tick(64'h0000_0001_0000_0800);
    pulse(2, 500, 1000);
    pulse(2, 900, 1700);
    tick(64'hFFFF_FFFF_FFFF_FFFF);
    tick(64'd0);
    drain();
    write_reg(RegChanEn, 12'h000);
    pulse(1, 0, 1500);
    tick(64'd5000);
    set_cal(12'd0, 12'd800, 12'd801, 12'd2200);
    write_reg(RegChanEn, 12'h03F);
    pulse(0, 0, 2200);
    pulse(1, 0, 800);
    tick(64'd3000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      case (ph)
        0: set_cal(12'd500, 12'd1100, 12'd1500, 12'd1900);
        1: set_cal(12'd20, 12'd800, 12'd1500, 12'd2200);
        2: set_cal(12'd2000, 12'd1000, 12'd1000, 12'd2000);
        3: set_cal(12'd4095, 12'd700, 12'd1500, 12'd2300);
        4: set_cal(12'd19, 12'd2000, 12'd2100, 12'd2200);
        5: set_cal(12'd2001, 12'd900, 12'd1200, 12'd2100);
        default: set_cal(12'($urandom), 12'($urandom_range(1200, 800)),
                         12'($urandom_range(1700, 1300)), 12'($urandom_range(2200, 1800)));
      endcase
      write_reg(RegChanEn, (ph == 4) ? 12'h015 :
                           ((ph == 5) ? 12'h03F : (12'($urandom) | 12'h021) & 12'h03F));
      random_phase(38);
      tick(clock_us);
    end

    while (pending_beats != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    $display("covered %0d edge beats and %0d ticks; %0d result beats were valid",
             edges_sent, ticks_seen, valid_beats);
    if (fail_count == 0 && pending_beats == 0)
      $display("tb_multi_channel_pwm_pulse_capture: clean");
    else
      $display("tb_multi_channel_pwm_pulse_capture: errors");
    $finish;
  end
endmodule
